/* rtl/rfpm_pkg.sv */
// Shared types, codes and arithmetic constants of the RF power mode manager.
package rfpm_pkg;

    // Mode codes
    localparam logic [1:0] MODE_ECO    = 2'd0;
    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_SPORT  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ECO_PCT    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPORT_PCT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_PCT  = 4'd7;
    localparam int CFG_DATA_W = 17;

    // Register reset values
    localparam logic [16:0] RST_THRESHOLD  = 17'd22000;
    localparam logic [12:0] RST_HYSTERESIS = 13'd500;
    localparam logic [15:0] RST_SETTLE     = 16'd2000;
    localparam logic [15:0] RST_START      = 16'd500;
    localparam logic [15:0] RST_TRACK      = 16'd5000;
    localparam logic [6:0]  RST_ECO_PCT    = 7'd70;
    localparam logic [6:0]  RST_SPORT_PCT  = 7'd100;
    localparam logic [5:0]  RST_FLOOR_PCT  = 6'd10;

    // Timing
    localparam logic [31:0] SWITCH_PERIOD_MS = 32'd100;
    localparam logic [31:0] SAMPLE_PERIOD_MS = 32'd50;

    // ADC to mV: 3300 * 104700 / (4095 * 4700) reduces to 76780 / 4277.
    // Rounded result = (adc * 76780 + 2138) / 4277, done as a multiply by
    // an exact reciprocal scaled by 2^41 (exact over the 12-bit input range).
    localparam int          CONV_SHIFT = 41;
    localparam longint unsigned CONV_NUM = 64'd76780;
    localparam longint unsigned CONV_DEN = 64'd4277;
    localparam longint unsigned CONV_RECIP =
        ((64'd1 << CONV_SHIFT) + CONV_DEN - 64'd1) / CONV_DEN;
    localparam longint unsigned CONV_MUL  = CONV_NUM * CONV_RECIP;
    localparam longint unsigned CONV_BIAS = ((CONV_DEN - 64'd1) / 64'd2) * CONV_RECIP;

    // Normal-mode mapping: 100 % at 21000 mV, 56 % at 36000 mV
    localparam logic [16:0] NORM_FULL_MV  = 17'd21000;
    localparam logic [6:0]  NORM_FULL_PCT = 7'd100;
    localparam longint unsigned NORM_SPAN  = 64'd36000 - 64'd21000;
    localparam longint unsigned NORM_SLOPE = 64'd100 - 64'd56;
    localparam int          MAP_SHIFT = 37;
    localparam longint unsigned MAP_RECIP =
        ((64'd1 << MAP_SHIFT) + NORM_SPAN - 64'd1) / NORM_SPAN;
    localparam longint unsigned MAP_MUL  = NORM_SLOPE * MAP_RECIP;
    localparam longint unsigned MAP_BIAS = (NORM_SPAN / 64'd2) * MAP_RECIP;

    typedef struct packed {
        logic [16:0] threshold_mv;
        logic [12:0] hysteresis_mv;
        logic [15:0] settle_ms;
        logic [15:0] start_delay_ms;
        logic [15:0] tracking_interval_ms;
        logic [6:0]  eco_percent;
        logic [6:0]  sport_percent;
        logic [5:0]  rf_floor_percent;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [11:0] adc_sample;
        logic        switch_grounded;
        logic        eco_jumper;
        logic        sport_jumper;
    } t_item;

    typedef struct packed {
        t_item       item;
        logic [16:0] raw_mv;
    } t_conv;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        eco_jumper;
        logic        sport_jumper;
        logic        shutdown_req;
        logic [16:0] filtered_mv;
    } t_filt;

    typedef struct packed {
        t_filt       filt;
        logic [6:0]  normal_pct;
        logic        above_upper;
        logic        below_lower;
        logic        above_thr;
    } t_mapd;

endpackage

/* rtl/rf_power_mode_manager_core.sv */
// Top level of the RF power mode manager: handshake, config registers, stage chain.
//
// RF power mode manager. Each input beat is one tick (time stamp, ADC sample,
// power switch level, mode jumpers) and yields exactly one result beat (RF
// write and percent, indicator pattern write with range and mode, indicator
// and fan levels, filtered voltage). The datapath is a five-register chain:
// input register, ADC-to-mV conversion, switch sampling plus low-pass filter,
// Normal-mode mapping plus range compares, and the control/result register.
// Each stage keeps its own state, so one beat is accepted every cycle while the
// output is not stalled, and a result beat is presented once its input beat has
// passed the conversion, filter, map and result registers; throughput is one beat
// per cycle, limited only by the output stall. Empty stages take beats while a
// finished result waits, so input beats keep flowing until the chain fills.
// Configuration registers are written through a separate valid/ready port that
// is always ready; write them only while no beat is in flight. There is no
// post-reset clearing pass: the block takes beats right after reset.
module rf_power_mode_manager_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tick input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [31:0]                     i_now_ms,
    input  logic [11:0]                     i_adc_sample,
    input  logic                            i_switch_grounded,
    input  logic                            i_eco_jumper,
    input  logic                            i_sport_jumper,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_rf_write,
    output logic [6:0]                      o_rf_percent,
    output logic                            o_pattern_write,
    output logic                            o_range_high,
    output logic [1:0]                      o_mode_out,
    output logic                            o_indicators_on,
    output logic                            o_fan_on,
    output logic [16:0]                     o_voltage_mv,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rfpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rfpm_pkg::t_cfg  r_cfg;
    rfpm_pkg::t_item r_item;
    rfpm_pkg::t_item w_item;
    rfpm_pkg::t_conv w_conv;
    rfpm_pkg::t_filt w_filt;
    rfpm_pkg::t_mapd w_mapd;

    // r_v[0] input reg, [1] conv, [2] filter, [3] map, [4] result
    logic [4:0] r_v;
    logic [4:0] w_ld;

    // ------------------------------------------------------------------
    // Configuration registers; writes masked to each register's width,
    // unknown indexes dropped.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_mv         <= rfpm_pkg::RST_THRESHOLD;
            r_cfg.hysteresis_mv        <= rfpm_pkg::RST_HYSTERESIS;
            r_cfg.settle_ms            <= rfpm_pkg::RST_SETTLE;
            r_cfg.start_delay_ms       <= rfpm_pkg::RST_START;
            r_cfg.tracking_interval_ms <= rfpm_pkg::RST_TRACK;
            r_cfg.eco_percent          <= rfpm_pkg::RST_ECO_PCT;
            r_cfg.sport_percent        <= rfpm_pkg::RST_SPORT_PCT;
            r_cfg.rf_floor_percent     <= rfpm_pkg::RST_FLOOR_PCT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rfpm_pkg::CFG_THRESHOLD:  r_cfg.threshold_mv         <= i_cfg_data;
                rfpm_pkg::CFG_HYSTERESIS: r_cfg.hysteresis_mv        <= i_cfg_data[12:0];
                rfpm_pkg::CFG_SETTLE:     r_cfg.settle_ms            <= i_cfg_data[15:0];
                rfpm_pkg::CFG_START:      r_cfg.start_delay_ms       <= i_cfg_data[15:0];
                rfpm_pkg::CFG_TRACK:      r_cfg.tracking_interval_ms <= i_cfg_data[15:0];
                rfpm_pkg::CFG_ECO_PCT:    r_cfg.eco_percent          <= i_cfg_data[6:0];
                rfpm_pkg::CFG_SPORT_PCT:  r_cfg.sport_percent        <= i_cfg_data[6:0];
                rfpm_pkg::CFG_FLOOR_PCT:  r_cfg.rf_floor_percent     <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when the one ahead of it holds a
    // beat and it is empty or being emptied in the same cycle.
    // ------------------------------------------------------------------
    assign w_ld[4] = r_v[3] && (!r_v[4] || !i_stall);
    assign w_ld[3] = r_v[2] && (!r_v[3] || w_ld[4]);
    assign w_ld[2] = r_v[1] && (!r_v[2] || w_ld[3]);
    assign w_ld[1] = r_v[0] && (!r_v[1] || w_ld[2]);
    assign o_stall = r_v[0] && !w_ld[1];
    assign w_ld[0] = i_valid && !o_stall;
    assign o_valid = r_v[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v[0] <= w_ld[0] || (r_v[0] && !w_ld[1]);
            r_v[1] <= w_ld[1] || (r_v[1] && !w_ld[2]);
            r_v[2] <= w_ld[2] || (r_v[2] && !w_ld[3]);
            r_v[3] <= w_ld[3] || (r_v[3] && !w_ld[4]);
            r_v[4] <= w_ld[4] || (r_v[4] && i_stall);
        end
    end

    // input register
    assign w_item.now_ms          = i_now_ms;
    assign w_item.adc_sample      = i_adc_sample;
    assign w_item.switch_grounded = i_switch_grounded;
    assign w_item.eco_jumper      = i_eco_jumper;
    assign w_item.sport_jumper    = i_sport_jumper;

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_item <= w_item;
        end
    end

    rfpm_conv u_conv (
        .i_clk  (i_clk),
        .i_load (w_ld[1]),
        .i_item (r_item),
        .o_conv (w_conv)
    );

    rfpm_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_ld[2]),
        .i_conv  (w_conv),
        .o_filt  (w_filt)
    );

    rfpm_map u_map (
        .i_clk  (i_clk),
        .i_load (w_ld[3]),
        .i_cfg  (r_cfg),
        .i_filt (w_filt),
        .o_mapd (w_mapd)
    );

    rfpm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_ld[4]),
        .i_cfg           (r_cfg),
        .i_mapd          (w_mapd),
        .o_rf_write      (o_rf_write),
        .o_rf_percent    (o_rf_percent),
        .o_pattern_write (o_pattern_write),
        .o_range_high    (o_range_high),
        .o_mode_out      (o_mode_out),
        .o_indicators_on (o_indicators_on),
        .o_fan_on        (o_fan_on),
        .o_voltage_mv    (o_voltage_mv)
    );

endmodule

/* rtl/rfpm_conv.sv */
// ADC sample to millivolt conversion stage.
module rfpm_conv (
    input  logic                i_clk,
    input  logic                i_load,
    input  rfpm_pkg::t_item     i_item,
    output rfpm_pkg::t_conv     o_conv
);

    logic [57:0]       w_prod;
    rfpm_pkg::t_conv   r_conv;

    // single constant multiply, reciprocal already folded in
    assign w_prod = {46'b0, i_item.adc_sample} * rfpm_pkg::CONV_MUL[57:0]
                  + rfpm_pkg::CONV_BIAS[57:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_conv.item   <= i_item;
            r_conv.raw_mv <= w_prod[rfpm_pkg::CONV_SHIFT +: 17];
        end
    end

    assign o_conv = r_conv;

endmodule

/* rtl/rfpm_filter.sv */
// Power switch sampling and 7/8 low-pass voltage filter stage.
module rfpm_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  rfpm_pkg::t_conv     i_conv,
    output rfpm_pkg::t_filt     o_filt
);

    logic        r_sw_seen, n_sw_seen;
    logic [31:0] r_last_sw, n_last_sw;
    logic        r_sreq, n_sreq;
    logic        r_filt_valid, n_filt_valid;
    logic [31:0] r_last_sample, n_last_sample;
    logic [16:0] r_filt, n_filt;
    logic [31:0] w_sw_age, w_sample_age;
    logic [19:0] w_acc;
    rfpm_pkg::t_filt r_out;

    assign w_sw_age     = i_conv.item.now_ms - r_last_sw;
    assign w_sample_age = i_conv.item.now_ms - r_last_sample;
    // 7 * old + new + 4, then divide by 8
    assign w_acc = ({r_filt, 3'b000} - {3'b000, r_filt}) + {3'b000, i_conv.raw_mv} + 20'd4;

    always_comb begin
        n_sw_seen     = r_sw_seen;
        n_last_sw     = r_last_sw;
        n_sreq        = r_sreq;
        n_filt_valid  = r_filt_valid;
        n_last_sample = r_last_sample;
        n_filt        = r_filt;
        if (!r_sw_seen || w_sw_age >= rfpm_pkg::SWITCH_PERIOD_MS) begin
            n_last_sw = i_conv.item.now_ms;
            n_sreq    = i_conv.item.switch_grounded;
            n_sw_seen = 1'b1;
        end
        // no sampling while shut down
        if (!n_sreq && (!r_filt_valid || w_sample_age >= rfpm_pkg::SAMPLE_PERIOD_MS)) begin
            n_last_sample = i_conv.item.now_ms;
            n_filt_valid  = 1'b1;
            if (!r_filt_valid) begin
                n_filt = i_conv.raw_mv;
            end else begin
                n_filt = w_acc[19:3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_seen     <= 1'b0;
            r_last_sw     <= '0;
            r_sreq        <= 1'b0;
            r_filt_valid  <= 1'b0;
            r_last_sample <= '0;
            r_filt        <= '0;
        end else if (i_load) begin
            r_sw_seen     <= n_sw_seen;
            r_last_sw     <= n_last_sw;
            r_sreq        <= n_sreq;
            r_filt_valid  <= n_filt_valid;
            r_last_sample <= n_last_sample;
            r_filt        <= n_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out.now_ms       <= i_conv.item.now_ms;
            r_out.eco_jumper   <= i_conv.item.eco_jumper;
            r_out.sport_jumper <= i_conv.item.sport_jumper;
            r_out.shutdown_req <= n_sreq;
            r_out.filtered_mv  <= n_filt;
        end
    end

    assign o_filt = r_out;

endmodule

/* rtl/rfpm_map.sv */
// Normal-mode RF mapping and range threshold compares.
module rfpm_map (
    input  logic                i_clk,
    input  logic                i_load,
    input  rfpm_pkg::t_cfg      i_cfg,
    input  rfpm_pkg::t_filt     i_filt,
    output rfpm_pkg::t_mapd     o_mapd
);

    logic [16:0] w_excess;
    logic [46:0] w_prod;
    logic [9:0]  w_drop;
    logic [9:0]  w_limit;
    logic [6:0]  w_pct;
    logic [11:0] w_half;
    logic [17:0] w_upper;
    logic [17:0] w_lower_sum;
    rfpm_pkg::t_mapd r_out;

    assign w_excess = i_filt.filtered_mv - rfpm_pkg::NORM_FULL_MV;
    // (excess * 44 + 7500) / 15000 as one constant multiply
    assign w_prod   = {30'b0, w_excess} * rfpm_pkg::MAP_MUL[46:0] + rfpm_pkg::MAP_BIAS[46:0];
    assign w_drop   = w_prod[rfpm_pkg::MAP_SHIFT +: 10];
    assign w_limit  = {3'b000, rfpm_pkg::NORM_FULL_PCT - {1'b0, i_cfg.rf_floor_percent}};

    always_comb begin
        if (i_filt.filtered_mv <= rfpm_pkg::NORM_FULL_MV) begin
            w_pct = rfpm_pkg::NORM_FULL_PCT;
        end else if (w_drop >= w_limit) begin
            w_pct = {1'b0, i_cfg.rf_floor_percent};
        end else begin
            w_pct = rfpm_pkg::NORM_FULL_PCT - w_drop[6:0];
        end
    end

    assign w_half      = i_cfg.hysteresis_mv[12:1];
    assign w_upper     = {1'b0, i_cfg.threshold_mv} + {6'b0, w_half};
    assign w_lower_sum = {1'b0, i_filt.filtered_mv} + {6'b0, w_half};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out.filt        <= i_filt;
            r_out.normal_pct  <= w_pct;
            r_out.above_upper <= {1'b0, i_filt.filtered_mv} > w_upper;
            r_out.below_lower <= w_lower_sum < {1'b0, i_cfg.threshold_mv};
            r_out.above_thr   <= i_filt.filtered_mv > i_cfg.threshold_mv;
        end
    end

    assign o_mapd = r_out;

endmodule

/* rtl/rfpm_ctrl.sv */
// Range/mode tracking, settle and apply control, result register.
module rfpm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  rfpm_pkg::t_cfg      i_cfg,
    input  rfpm_pkg::t_mapd     i_mapd,
    output logic                o_rf_write,
    output logic [6:0]          o_rf_percent,
    output logic                o_pattern_write,
    output logic                o_range_high,
    output logic [1:0]          o_mode_out,
    output logic                o_indicators_on,
    output logic                o_fan_on,
    output logic [16:0]         o_voltage_mv
);

    logic        r_sd_done, n_sd_done;
    logic        r_seen, n_seen;
    logic        r_cur_range, n_cur_range;
    logic [1:0]  r_cur_mode, n_cur_mode;
    logic [31:0] r_range_ms, n_range_ms;
    logic [31:0] r_mode_ms, n_mode_ms;
    logic        r_app_valid, n_app_valid;
    logic        r_app_range, n_app_range;
    logic [1:0]  r_app_mode, n_app_mode;
    logic [31:0] r_track_ms, n_track_ms;

    logic        r_rf_write, n_rf_write;
    logic [6:0]  r_rf_pct, n_rf_pct;
    logic        r_pat_write, n_pat_write;
    logic        r_fan_on;
    logic [16:0] r_volt;

    logic [31:0] w_now;
    logic [1:0]  w_mode;
    logic        w_range;
    logic [31:0] w_range_age, w_mode_age, w_track_age;
    logic        w_range_stable, w_mode_stable, w_apply;
    logic [6:0]  w_pct;

    assign w_now = i_mapd.filt.now_ms;

    always_comb begin
        if (i_mapd.filt.eco_jumper) begin
            w_mode = rfpm_pkg::MODE_ECO;
        end else if (i_mapd.filt.sport_jumper) begin
            w_mode = rfpm_pkg::MODE_SPORT;
        end else begin
            w_mode = rfpm_pkg::MODE_NORMAL;
        end
    end

    // range class with hysteresis; first beat takes a plain compare
    always_comb begin
        w_range = r_cur_range;
        if (!r_seen) begin
            w_range = i_mapd.above_thr;
        end else if (!r_cur_range && i_mapd.above_upper) begin
            w_range = 1'b1;
        end else if (r_cur_range && i_mapd.below_lower) begin
            w_range = 1'b0;
        end
    end

    always_comb begin
        n_sd_done   = r_sd_done;
        n_seen      = r_seen;
        n_cur_range = r_cur_range;
        n_cur_mode  = r_cur_mode;
        n_range_ms  = r_range_ms;
        n_mode_ms   = r_mode_ms;
        n_app_valid = r_app_valid;
        n_app_range = r_app_range;
        n_app_mode  = r_app_mode;
        n_track_ms  = r_track_ms;
        n_rf_write  = 1'b0;
        n_rf_pct    = 7'd0;
        n_pat_write = 1'b0;
        w_apply     = 1'b0;

        if (i_mapd.filt.shutdown_req) begin
            // one zero write on entry, then hold
            if (!r_sd_done) begin
                n_rf_write  = 1'b1;
                n_app_valid = 1'b0;
                n_sd_done   = 1'b1;
            end
        end else begin
            n_sd_done = 1'b0;
            if (!r_seen) begin
                n_cur_range = w_range;
                n_cur_mode  = w_mode;
                n_range_ms  = w_now;
                n_mode_ms   = w_now;
                n_seen      = 1'b1;
            end else begin
                if (w_range != r_cur_range) begin
                    n_cur_range = w_range;
                    n_range_ms  = w_now;
                end
                if (w_mode != r_cur_mode) begin
                    n_cur_mode = w_mode;
                    n_mode_ms  = w_now;
                end
            end

            if (!r_app_valid) begin
                w_apply = w_now >= {16'b0, i_cfg.start_delay_ms};
            end else begin
                if (w_mode_stable && n_cur_mode == rfpm_pkg::MODE_NORMAL &&
                    r_app_mode == rfpm_pkg::MODE_NORMAL &&
                    w_track_age >= {16'b0, i_cfg.tracking_interval_ms}) begin
                    n_rf_write = 1'b1;
                    n_rf_pct   = i_mapd.normal_pct;
                    n_track_ms = w_now;
                end
                w_apply = w_range_stable && w_mode_stable &&
                          (n_cur_range != r_app_range || n_cur_mode != r_app_mode);
            end

            if (w_apply) begin
                if (!r_app_valid || n_cur_mode != r_app_mode) begin
                    n_rf_write = 1'b1;
                    n_rf_pct   = w_pct;
                    if (n_cur_mode == rfpm_pkg::MODE_NORMAL) begin
                        n_track_ms = w_now;
                    end
                end
                n_pat_write = 1'b1;
                n_app_range = n_cur_range;
                n_app_mode  = n_cur_mode;
                n_app_valid = 1'b1;
            end
        end
    end

    // ages measured against the change stamps as updated by this beat:
    // a stamp that moves now has age zero
    assign w_range_age    = (!r_seen || w_range != r_cur_range) ? 32'd0 : w_now - r_range_ms;
    assign w_mode_age     = (!r_seen || w_mode != r_cur_mode) ? 32'd0 : w_now - r_mode_ms;
    assign w_track_age    = w_now - r_track_ms;
    assign w_range_stable = w_range_age >= {16'b0, i_cfg.settle_ms};
    assign w_mode_stable  = w_mode_age >= {16'b0, i_cfg.settle_ms};

    // outside shutdown the current mode always ends up equal to the jumper mode
    always_comb begin
        case (w_mode)
            rfpm_pkg::MODE_ECO:   w_pct = i_cfg.eco_percent;
            rfpm_pkg::MODE_SPORT: w_pct = i_cfg.sport_percent;
            default:              w_pct = i_mapd.normal_pct;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd_done   <= 1'b0;
            r_seen      <= 1'b0;
            r_cur_range <= 1'b0;
            r_cur_mode  <= rfpm_pkg::MODE_NORMAL;
            r_range_ms  <= '0;
            r_mode_ms   <= '0;
            r_app_valid <= 1'b0;
            r_app_range <= 1'b0;
            r_app_mode  <= rfpm_pkg::MODE_NORMAL;
            r_track_ms  <= '0;
        end else if (i_load) begin
            r_sd_done   <= n_sd_done;
            r_seen      <= n_seen;
            r_cur_range <= n_cur_range;
            r_cur_mode  <= n_cur_mode;
            r_range_ms  <= n_range_ms;
            r_mode_ms   <= n_mode_ms;
            r_app_valid <= n_app_valid;
            r_app_range <= n_app_range;
            r_app_mode  <= n_app_mode;
            r_track_ms  <= n_track_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rf_write  <= n_rf_write;
            r_rf_pct    <= n_rf_pct;
            r_pat_write <= n_pat_write;
            r_fan_on    <= !i_mapd.filt.shutdown_req;
            r_volt      <= i_mapd.filt.filtered_mv;
        end
    end

    // applied range/mode and shutdown flag only move on a load, so they
    // double as the result fields
    assign o_rf_write      = r_rf_write;
    assign o_rf_percent    = r_rf_pct;
    assign o_pattern_write = r_pat_write;
    assign o_range_high    = r_app_range;
    assign o_mode_out      = r_app_mode;
    assign o_indicators_on = !r_sd_done;
    assign o_fan_on        = r_fan_on;
    assign o_voltage_mv    = r_volt;

endmodule

/* bench/tb_rf_power_mode_manager_core.sv */
// Self-checking testbench for rf_power_mode_manager_core: directed table, then random ticks.
`timescale 1ns / 1ps

module tb_rf_power_mode_manager_core;
    import rfpm_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int ROW_COUNT        = 16;
    localparam int PHASE_COUNT      = 6;
    localparam int TICKS_PER_PHASE  = 125;
    localparam int CALM_TICKS       = 30;   // opening stretch of each phase with no idling
    localparam int MIDPHASE_DRAIN   = 70;   // sender holds off here until all results are in
    localparam int END_SETTLE       = 20;   // pipeline is five stages deep
    localparam int WATCHDOG_CYCLES  = 2000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;  // above the register file

    // Timing and arithmetic of the manager
    localparam logic [31:0]     SWITCH_POLL_MS = 32'd100;
    localparam logic [31:0]     ADC_POLL_MS    = 32'd50;
    localparam longint unsigned ADC_NUM        = 64'd3300 * 64'd104700;  // ref mV x divider total
    localparam longint unsigned ADC_DEN        = 64'd4095 * 64'd4700;    // full code x lower leg
    localparam longint unsigned FILT_DIV       = 64'd8;
    localparam longint unsigned MAP_FULL_MV    = 64'd21000;
    localparam longint unsigned MAP_FULL_PCT   = 64'd100;
    localparam longint unsigned MAP_SPAN       = 64'd36000 - 64'd21000;
    localparam longint unsigned MAP_SLOPE      = 64'd100 - 64'd56;

    typedef struct packed {
        logic        rf_write;
        logic [6:0]  rf_percent;
        logic        pattern_write;
        logic        range_high;
        logic [1:0]  mode_out;
        logic        indicators_on;
        logic        fan_on;
        logic [16:0] voltage_mv;
    } t_tick_out;

    typedef struct packed {
        t_item     it;
        logic      fixed;     // expectation typed into the table
        t_tick_out want;
    } t_row;

    localparam t_tick_out NO_TYPED = '0;

    // Directed ticks. The first five are typed in: boot before the start delay, a
    // shutdown request caught by the 100 ms switch poll, the single zero RF beat,
    // and the release that turns indicators and fan back on.
    localparam t_row DIRECTED [ROW_COUNT] = '{
        '{'{32'd0, 12'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{1'b0, 7'd0, 1'b0, 1'b0, MODE_NORMAL, 1'b1, 1'b1, 17'd0}},
        // no ADC sample yet: less than 50 ms since the seed
        '{'{32'd10, 12'd4095, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{1'b0, 7'd0, 1'b0, 1'b0, MODE_NORMAL, 1'b1, 1'b1, 17'd0}},
        // switch poll sees ground: one RF write of zero
        '{'{32'd100, 12'd4095, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{1'b1, 7'd0, 1'b0, 1'b0, MODE_NORMAL, 1'b0, 1'b0, 17'd0}},
        // still shut down, jumpers ignored, no second write
        '{'{32'd150, 12'd4095, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{1'b0, 7'd0, 1'b0, 1'b0, MODE_NORMAL, 1'b0, 1'b0, 17'd0}},
        // released, still before the start delay
        '{'{32'd200, 12'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{1'b0, 7'd0, 1'b0, 1'b0, MODE_NORMAL, 1'b1, 1'b1, 17'd0}},
        // start delay reached with both jumpers: eco wins
        '{'{32'd500, 12'd4095, 1'b0, 1'b1, 1'b1}, 1'b0, NO_TYPED},
        '{'{32'd550, 12'd4095, 1'b0, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'd600, 12'd2048, 1'b0, 1'b0, 1'b1}, 1'b0, NO_TYPED},
        // sport settled
        '{'{32'd2700, 12'd4095, 1'b0, 1'b0, 1'b1}, 1'b0, NO_TYPED},
        '{'{32'd2750, 12'd1500, 1'b0, 1'b0, 1'b0}, 1'b0, NO_TYPED},
        // normal settled, mapped RF
        '{'{32'd4800, 12'd1500, 1'b0, 1'b0, 1'b0}, 1'b0, NO_TYPED},
        // tracking interval elapsed
        '{'{32'd9900, 12'd4095, 1'b0, 1'b0, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'hFFFF_FFF0, 12'd4095, 1'b0, 1'b0, 1'b0}, 1'b0, NO_TYPED},
        // across the time wrap: shutdown, then release with now below the start delay
        '{'{32'h0000_0060, 12'd4095, 1'b1, 1'b0, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'h0000_00D0, 12'd4095, 1'b0, 1'b0, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'hFFFF_FFFF, 12'd1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_TYPED}
    };

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [31:0]           i_now_ms = '0;
    logic [11:0]           i_adc_sample = '0;
    logic                  i_switch_grounded = 1'b0;
    logic                  i_eco_jumper = 1'b0;
    logic                  i_sport_jumper = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_rf_write;
    logic [6:0]            o_rf_percent;
    logic                  o_pattern_write;
    logic                  o_range_high;
    logic [1:0]            o_mode_out;
    logic                  o_indicators_on;
    logic                  o_fan_on;
    logic [16:0]           o_voltage_mv;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    rf_power_mode_manager_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_now_ms          (i_now_ms),
        .i_adc_sample      (i_adc_sample),
        .i_switch_grounded (i_switch_grounded),
        .i_eco_jumper      (i_eco_jumper),
        .i_sport_jumper    (i_sport_jumper),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_rf_write        (o_rf_write),
        .o_rf_percent      (o_rf_percent),
        .o_pattern_write   (o_pattern_write),
        .o_range_high      (o_range_high),
        .o_mode_out        (o_mode_out),
        .o_indicators_on   (o_indicators_on),
        .o_fan_on          (o_fan_on),
        .o_voltage_mv      (o_voltage_mv),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Manager model state (reset values) and register shadow
    // ------------------------------------------------------------------
    t_cfg        cfg_shadow = '{17'd22000, 13'd500, 16'd2000, 16'd500, 16'd5000,
                                7'd70, 7'd100, 6'd10};
    logic        sw_seen = 1'b0, shut_req = 1'b0, shut_done = 1'b0;
    logic        filt_ok = 1'b0, first_seen = 1'b0, applied_ok = 1'b0;
    logic        range_now = 1'b0, range_applied = 1'b0;
    logic [1:0]  mode_now = MODE_NORMAL, mode_applied = MODE_NORMAL;
    logic [31:0] sw_time = '0, sample_time = '0, range_time = '0;
    logic [31:0] mode_time = '0, track_time = '0;
    logic [16:0] volt_mv = '0;

    // Scoreboard and bench control
    t_tick_out   results_due[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    logic        calm = 1'b1;
    logic        fixed_on = 1'b0;
    t_tick_out   fixed_want = '0;

    // Random tick source: a slowly moving "plant"
    logic [31:0] clock_ms = '0;
    int          adc_level = 1200;
    logic        sw_level = 1'b0, eco_level = 1'b0, sport_level = 1'b0;

    // ------------------------------------------------------------------
    // Normal-mode RF mapping: full power up to 21 V, linear down, floor clamp
    // ------------------------------------------------------------------
    function automatic logic [6:0] track_percent(input logic [16:0] v);
        longint unsigned drop;
        if (64'(v) <= MAP_FULL_MV)
            return 7'(MAP_FULL_PCT);
        drop = ((64'(v) - MAP_FULL_MV) * MAP_SLOPE + MAP_SPAN / 64'd2) / MAP_SPAN;
        if (drop >= MAP_FULL_PCT - 64'(cfg_shadow.rf_floor_percent))
            return 7'(cfg_shadow.rf_floor_percent);
        return 7'(MAP_FULL_PCT - drop);
    endfunction

    function automatic logic [6:0] mode_target(input logic [1:0] m, input logic [16:0] v);
        if (m == MODE_ECO)
            return cfg_shadow.eco_percent;
        if (m == MODE_SPORT)
            return cfg_shadow.sport_percent;
        return track_percent(v);
    endfunction

    // Latch the current range/mode as applied; RF is reissued only on a mode
    // change or when nothing was applied yet.
    task automatic commit_state(input logic [31:0] now, inout t_tick_out r);
        if (!applied_ok || mode_now != mode_applied) begin
            r.rf_write   = 1'b1;
            r.rf_percent = mode_target(mode_now, volt_mv);
            if (mode_now == MODE_NORMAL)
                track_time = now;
        end
        r.pattern_write = 1'b1;
        range_applied   = range_now;
        mode_applied    = mode_now;
        applied_ok      = 1'b1;
    endtask

    // One tick through the manager
    task automatic step_manager(input t_item it, output t_tick_out r);
        longint unsigned raw;
        int unsigned     v32, thr32, half32;
        logic [1:0]      pick;
        logic            next_range, range_ok, mode_ok;
        r = '0;
        if (!sw_seen || (it.now_ms - sw_time) >= SWITCH_POLL_MS) begin
            sw_time  = it.now_ms;
            shut_req = it.switch_grounded;
            sw_seen  = 1'b1;
        end
        if (shut_req) begin
            // single zero write on entry; no sampling or classification
            if (!shut_done) begin
                r.rf_write = 1'b1;
                applied_ok = 1'b0;
                shut_done  = 1'b1;
            end
        end else begin
            shut_done = 1'b0;
            if (!filt_ok || (it.now_ms - sample_time) >= ADC_POLL_MS) begin
                raw = (64'(it.adc_sample) * ADC_NUM + ADC_DEN / 64'd2) / ADC_DEN;
                sample_time = it.now_ms;
                if (!filt_ok) begin
                    volt_mv = 17'(raw);
                    filt_ok = 1'b1;
                end else begin
                    volt_mv = 17'((64'(volt_mv) * (FILT_DIV - 64'd1) + raw + FILT_DIV / 64'd2)
                                  / FILT_DIV);
                end
            end

            pick = it.eco_jumper ? MODE_ECO : (it.sport_jumper ? MODE_SPORT : MODE_NORMAL);
            if (!first_seen) begin
                range_now  = volt_mv > cfg_shadow.threshold_mv;
                mode_now   = pick;
                range_time = it.now_ms;
                mode_time  = it.now_ms;
                first_seen = 1'b1;
            end else begin
                half32     = 32'(cfg_shadow.hysteresis_mv) / 32'd2;
                v32        = 32'(volt_mv);
                thr32      = 32'(cfg_shadow.threshold_mv);
                next_range = range_now;
                if (!range_now && v32 > thr32 + half32)
                    next_range = 1'b1;
                else if (range_now && v32 + half32 < thr32)
                    next_range = 1'b0;
                if (next_range != range_now) begin
                    range_now  = next_range;
                    range_time = it.now_ms;
                end
                if (pick != mode_now) begin
                    mode_now  = pick;
                    mode_time = it.now_ms;
                end
            end

            if (!applied_ok) begin
                if (it.now_ms >= 32'(cfg_shadow.start_delay_ms))
                    commit_state(it.now_ms, r);
            end else begin
                range_ok = (it.now_ms - range_time) >= 32'(cfg_shadow.settle_ms);
                mode_ok  = (it.now_ms - mode_time) >= 32'(cfg_shadow.settle_ms);
                if (mode_ok && mode_now == MODE_NORMAL && mode_applied == MODE_NORMAL &&
                    (it.now_ms - track_time) >= 32'(cfg_shadow.tracking_interval_ms)) begin
                    r.rf_write   = 1'b1;
                    r.rf_percent = track_percent(volt_mv);
                    track_time   = it.now_ms;
                end
                if (range_ok && mode_ok &&
                    (range_now != range_applied || mode_now != mode_applied))
                    commit_state(it.now_ms, r);
            end
        end
        r.range_high    = range_applied;
        r.mode_out      = mode_applied;
        r.indicators_on = !shut_done;
        r.fan_on        = !shut_req;
        r.voltage_mv    = volt_mv;
    endtask

    // ------------------------------------------------------------------
    // Monitor: register writes, accepted ticks, result beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_tick_out pred, want, got;
        logic      busy;
        busy = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                busy = 1'b1;
                case (i_cfg_index)
                    CFG_THRESHOLD:  cfg_shadow.threshold_mv         = i_cfg_data[16:0];
                    CFG_HYSTERESIS: cfg_shadow.hysteresis_mv        = i_cfg_data[12:0];
                    CFG_SETTLE:     cfg_shadow.settle_ms            = i_cfg_data[15:0];
                    CFG_START:      cfg_shadow.start_delay_ms       = i_cfg_data[15:0];
                    CFG_TRACK:      cfg_shadow.tracking_interval_ms = i_cfg_data[15:0];
                    CFG_ECO_PCT:    cfg_shadow.eco_percent          = i_cfg_data[6:0];
                    CFG_SPORT_PCT:  cfg_shadow.sport_percent        = i_cfg_data[6:0];
                    CFG_FLOOR_PCT:  cfg_shadow.rf_floor_percent     = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                busy = 1'b1;
                step_manager('{i_now_ms, i_adc_sample, i_switch_grounded, i_eco_jumper,
                               i_sport_jumper}, pred);
                results_due.push_back(fixed_on ? fixed_want : pred);
            end
            if (o_valid && !i_stall) begin
                busy = 1'b1;
                got = '{o_rf_write, o_rf_percent, o_pattern_write, o_range_high, o_mode_out,
                        o_indicators_on, o_fan_on, o_voltage_mv};
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result beat with nothing expected", $time);
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: mismatch rf %b/%0d pat %b rng %b mode %0d ind %b fan %b mv %0d",
                                     $time, want.rf_write, want.rf_percent, want.pattern_write,
                                     want.range_high, want.mode_out, want.indicators_on,
                                     want.fan_on, want.voltage_mv);
                            $display("      got    rf %b/%0d pat %b rng %b mode %0d ind %b fan %b mv %0d",
                                     got.rf_write, got.rf_percent, got.pattern_write,
                                     got.range_high, got.mode_out, got.indicators_on,
                                     got.fan_on, got.voltage_mv);
                        end
                    end
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
        end
    end

    // Receiver back-pressure, changed on the falling edge
    always @(negedge i_clk) begin
        int r;
        r = int'($urandom_range(0, 99));
        if (!i_rst_n || (calm && stall_left == 0)) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (r < 65) begin
            i_stall <= 1'b0;
        end else begin
            stall_left = (r < 93) ? int'($urandom_range(0, 2)) : int'($urandom_range(9, 39));
            i_stall <= 1'b1;
        end
    end

    // Watchdog: too long with no beat moving anywhere
    initial begin
        wait (quiet_cycles >= WATCHDOG_CYCLES);
        $display("rf_power_mode_manager_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (all called right after a falling edge)
    // ------------------------------------------------------------------
    function automatic int sender_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    task automatic send_tick(input t_item it, input logic fixed, input t_tick_out want);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_now_ms          = it.now_ms;
        i_adc_sample      = it.adc_sample;
        i_switch_grounded = it.switch_grounded;
        i_eco_jumper      = it.eco_jumper;
        i_sport_jumper    = it.sport_jumper;
        fixed_on          = fixed;
        fixed_want        = want;
        i_valid           = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every expected result beat has arrived
    task automatic drain();
        i_valid = 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_settings(input logic [16:0] thr, input logic [16:0] hyst,
                                 input logic [16:0] settle, input logic [16:0] start,
                                 input logic [16:0] track, input logic [16:0] eco,
                                 input logic [16:0] sport, input logic [16:0] floor_pct);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_HYSTERESIS, hyst);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_START, start);
        write_reg(CFG_TRACK, track);
        write_reg(CFG_ECO_PCT, eco);
        write_reg(CFG_SPORT_PCT, sport);
        write_reg(CFG_FLOOR_PCT, floor_pct);
    endtask

    // Mostly a plausible supply: time moving forward, ADC drifting around a
    // level, switch and jumpers changing now and then. A few ticks are noise.
    task automatic next_tick(output t_item it);
        int r, a;
        r = int'($urandom_range(0, 99));
        if (r < 5) begin
            it.now_ms          = $urandom();
            it.adc_sample      = 12'($urandom());
            it.switch_grounded = 1'($urandom());
            it.eco_jumper      = 1'($urandom());
            it.sport_jumper    = 1'($urandom());
        end else begin
            r = int'($urandom_range(0, 99));
            if (r < 70)
                clock_ms = clock_ms + $urandom_range(0, 60);
            else if (r < 92)
                clock_ms = clock_ms + $urandom_range(61, 400);
            else if (r < 99)
                clock_ms = clock_ms + $urandom_range(401, 6000);
            else
                clock_ms = $urandom();
            if ($urandom_range(0, 99) < 4)
                adc_level = $urandom_range(0, 1) ? int'($urandom_range(700, 2600))
                                                 : int'($urandom_range(0, 4095));
            a = adc_level + int'($urandom_range(0, 40)) - 20;
            if (a < 0)
                a = 0;
            if (a > 4095)
                a = 4095;
            // grounding is rare, release comes quickly
            if (sw_level ? ($urandom_range(0, 99) < 10) : ($urandom_range(0, 99) < 1))
                sw_level = !sw_level;
            if ($urandom_range(0, 99) < 3)
                eco_level = !eco_level;
            if ($urandom_range(0, 99) < 3)
                sport_level = !sport_level;
            it.now_ms          = clock_ms;
            it.adc_sample      = 12'(a);
            it.switch_grounded = sw_level;
            it.eco_jumper      = eco_level;
            it.sport_jumper    = sport_level;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int    k, p;
        t_item it;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        calm    = 1'b0;

        for (k = 0; k < ROW_COUNT; k++)
            send_tick(DIRECTED[k].it, DIRECTED[k].fixed, DIRECTED[k].want);
        clock_ms = DIRECTED[ROW_COUNT-1].it.now_ms;

        for (p = 0; p < PHASE_COUNT; p++) begin
            drain();
            case (p)
                0: ;  // reset settings
                1: begin
                    // all zero; a write above the register file must change nothing
                    load_settings('0, '0, '0, '0, '0, '0, '0, '0);
                    write_reg(CFG_UNUSED, '1);
                end
                2: begin
                    // widest values; upper data bits are dropped per register
                    load_settings('1, '1, '1, '1, '1, '1, 17'h1FF64, 17'h1FFF8);
                end
                3: begin
                    // hysteresis half wider than the threshold: no way back to low range
                    load_settings(17'($urandom_range(0, 3000)), 17'd8191,
                                  17'($urandom_range(0, 200)), '0,
                                  17'($urandom_range(0, 300)), 17'($urandom_range(0, 100)),
                                  17'($urandom_range(0, 100)), 17'($urandom_range(0, 56)));
                end
                default: begin
                    load_settings(17'($urandom_range(15000, 30000)), 17'($urandom_range(0, 3000)),
                                  17'($urandom_range(0, 600)), 17'($urandom_range(0, 3000)),
                                  17'($urandom_range(0, 800)), 17'($urandom_range(0, 100)),
                                  17'($urandom_range(0, 100)), 17'($urandom_range(0, 56)));
                end
            endcase
            for (k = 0; k < TICKS_PER_PHASE; k++) begin
                calm = (k < CALM_TICKS);
                if (k == MIDPHASE_DRAIN)
                    drain();
                next_tick(it);
                send_tick(it, 1'b0, NO_TYPED);
            end
        end

        drain();
        calm = 1'b1;
        repeat (END_SETTLE) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("rf_power_mode_manager_core verification clean");
        else
            $display("rf_power_mode_manager_core verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/rfpm_pkg.sv
rtl/rfpm_conv.sv
rtl/rfpm_filter.sv
rtl/rfpm_map.sv
rtl/rfpm_ctrl.sv
rtl/rf_power_mode_manager_core.sv
bench/tb_rf_power_mode_manager_core.sv
